FILE: rtl/bba_pkg.sv
// Shared types, constants and helper functions of the buddy block allocator.
// Used by every module of the block; depends on nothing.
package bba_pkg;

  localparam int MIN_BLOCK  = 128;
  localparam int MIN_SHIFT  = 7;
  localparam int MAX_ORDER  = 10;
  localparam int TOP_BLOCKS = 32;
  localparam int UNITS      = TOP_BLOCKS << MAX_ORDER;
  localparam int UNIT_W     = $clog2(UNITS);
  localparam int ORDER_W    = 4;
  localparam int SIZE_W     = 17;
  localparam int REQ_W      = 27;
  localparam int OFF_W      = 22;
  localparam int HDR_W      = 7;
  localparam int CNT_W      = 16;
  localparam int BYTES_W    = 23;
  localparam int TBYTES_W   = 24;
  localparam int CAP_W      = 18;
  localparam int BM_AW      = 10;
  localparam int MID_AW     = 4;
  localparam int MID_WORDS  = 1 << MID_AW;
  localparam int IN_W       = 56;
  localparam int OUT_W      = 104;
  localparam int SIZE_LIMIT = 100000000;
  localparam int TOP_SIZE   = MIN_BLOCK << MAX_ORDER;
  localparam int HDR_RESET  = 32;
  localparam int STAT_LAST  = MAX_ORDER + 1;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_RESIZE = 2'd2,
    ACT_STATS  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_MEM    = 3'd3,
    ST_IGNORED   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_LOOKCHK, S_FIND, S_SWORD, S_SBIT,
    S_UPD_RD, S_UPD_WR, S_SPLIT, S_FREE, S_MRG_RD, S_MRG_CHK,
    S_MRG_ADD, S_STAT, S_OUT
  } state_e;

  typedef struct packed {
    logic               start;
    logic               free;
    logic [ORDER_W-1:0] order;
    logic [SIZE_W-1:0]  size;
  } entry_t;

  // One classified request as it travels from front to back
  typedef struct packed {
    action_e            action;
    status_e            alloc_st;
    logic [ORDER_W-1:0] d;
    logic [REQ_W-1:0]   req;
    logic [UNIT_W-1:0]  unit;
    logic               lk_ok;
    logic               has_old;
  } cmd_t;

  // Bitmap words used by one order
  function automatic int bm_words(int k);
    int n;
    n = (UNITS >> k) >> 6;
    return (n == 0) ? 1 : n;
  endfunction

  // First bitmap word of an order
  function automatic logic [BM_AW-1:0] bm_base(logic [ORDER_W-1:0] k);
    int acc;
    acc = 0;
    for (int j = 0; j < MAX_ORDER; j++) begin
      if (j < int'(k)) acc = acc + bm_words(j);
    end
    return BM_AW'(acc);
  endfunction

  // Last bitmap word of an order
  function automatic logic [BM_AW-1:0] bm_last(logic [ORDER_W-1:0] k);
    int acc;
    acc = 0;
    for (int j = 0; j <= MAX_ORDER; j++) begin
      if (j <= int'(k)) acc = acc + bm_words(j);
    end
    return BM_AW'(acc - 1);
  endfunction

  // Payload capacity of a block of order k, floored at zero
  function automatic logic [CAP_W-1:0] blk_cap(logic [ORDER_W-1:0] k,
                                               logic [HDR_W-1:0] h);
    logic [CAP_W-1:0] bs;
    bs = CAP_W'(MIN_BLOCK) << k;
    return (bs > CAP_W'(h)) ? bs - CAP_W'(h) : '0;
  endfunction

  // Index of the lowest set bit
  function automatic logic [5:0] lowest_set(logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

FILE: rtl/bba_front.sv
// Front end: takes requests from the input stream and classifies them.
// Depends on bba_pkg; feeds bba_queue.
module bba_front import bba_pkg::*; (
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // action[1:0], request_bytes[28:2], payload_offset[50:29], has_old[51], zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic [HDR_W-1:0] header_i,
  input  logic             q_full_i,
  input  logic             init_done_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic [REQ_W-1:0]   req;
  logic [OFF_W-1:0]   off;
  logic [OFF_W-1:0]   rem;
  logic [REQ_W:0]     need;
  logic [MAX_ORDER:0] fit;
  logic [ORDER_W-1:0] d;
  logic               bad;

  assign req = s_axis_tdata[28:2];
  assign off = s_axis_tdata[50:29];

  // Accept while the queue has room and the clearing pass is over
  assign s_axis_tready = !q_full_i && init_done_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  // Pick the smallest order that holds size plus header
  always_comb begin
    need = {1'b0, req} + (REQ_W+1)'(header_i);
    d    = '0;
    for (int k = 0; k <= MAX_ORDER; k++) begin
      fit[k] = ((REQ_W+1)'(MIN_BLOCK) << k) >= need;
    end
    for (int k = MAX_ORDER; k >= 0; k--) begin
      if (fit[k]) d = ORDER_W'(k);
    end
  end

  assign bad = (req == '0) || (req > REQ_W'(SIZE_LIMIT));
  assign rem = off - OFF_W'(header_i);

  // Build the request record
  always_comb begin
    cmd_o.action  = action_e'(s_axis_tdata[1:0]);
    cmd_o.req     = req;
    cmd_o.d       = d;
    cmd_o.has_old = s_axis_tdata[51];
    cmd_o.unit    = rem[OFF_W-1:MIN_SHIFT];
    cmd_o.lk_ok   = (off >= OFF_W'(header_i)) && (rem[MIN_SHIFT-1:0] == '0);
    if (bad) begin
      cmd_o.alloc_st = ST_BAD_SIZE;
    end else if ((req >= REQ_W'(TOP_SIZE)) || !(|fit)) begin
      cmd_o.alloc_st = ST_TOO_LARGE;
    end else begin
      cmd_o.alloc_st = ST_OK;
    end
  end

endmodule

FILE: rtl/bba_queue.sv
// Two-entry queue of classified requests between front and back.
// Depends on bba_pkg for the request record.
module bba_queue import bba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign cmd_o   = slot_q[rptr_q];

  // Store the payload
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= cmd_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

FILE: rtl/bba_back.sv
// Back end: block table, free bitmaps and the sequencer that allocates,
// splits, frees and merges, then sums statistics. Depends on bba_pkg.
module bba_back import bba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [HDR_W-1:0] header_i,
  input  logic             q_empty_i,
  input  cmd_t             q_cmd_i,
  output logic             q_pop_o,
  output logic             init_done_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata
);

  // Memories
  entry_t       tbl_mem [UNITS];
  logic [63:0]  bm_mem  [1 << BM_AW];
  logic [63:0]  mid_mem [MID_WORDS];

  logic              tbl_we;
  logic [UNIT_W-1:0] tbl_waddr, tbl_raddr;
  entry_t            tbl_wdata, tbl_rdata_q;
  logic              bm_we;
  logic [BM_AW-1:0]  bm_waddr, bm_raddr;
  logic [63:0]       bm_wdata, bm_rdata_q;
  logic              mid_we;
  logic [MID_AW-1:0] mid_waddr, mid_raddr;
  logic [63:0]       mid_wdata, mid_rdata_q;

  state_e state_q, state_d, ret_q;
  cmd_t   cmd_q;

  logic [UNIT_W-1:0]  init_cnt_q, u_q, old_q, b_q, res_q, upd_unit_q;
  logic [ORDER_W-1:0] k_q, d_q, old_order_q, upd_k_q;
  logic [SIZE_W-1:0]  old_size_q;
  logic [MID_AW-1:0]  m_q;
  logic [BM_AW-1:0]   wa_q;
  logic               upd_set_q, grant_q, free_old_q, out_valid_q;
  status_e            status_q;
  logic [MID_WORDS-1:0] top_q;
  logic [CNT_W-1:0]   cnt_q [MAX_ORDER+1];
  logic [CNT_W-1:0]   fbc_q, live_cnt_q;
  logic [BYTES_W-1:0] live_bytes_q;
  logic [TBYTES_W-1:0] prod_q, acc_q;
  logic [ORDER_W-1:0] stat_i_q;
  logic [OUT_W-1:0]   out_data_q;

  // Derived control values
  logic [UNIT_W-1:0]  upd_pos, sbit_unit, split_unit, merge_b;
  logic [BM_AW-1:0]   upd_wa, sword_wa, lo_k, hi_k, lo_f, hi_f;
  logic [63:0]        upd_word, upd_mid, word_mask;
  logic [MID_WORDS-1:0] top_mask;
  logic [ORDER_W-1:0] find_k;
  logic               find_ok;
  logic [MID_AW-1:0]  find_m;
  logic [5:0]         sbit_bit;
  logic               live_ok, merge_ok, fits_inplace, out_free;
  logic [CAP_W-1:0]   old_cap;
  logic [BM_AW-1:0]   bm_init_wa;
  logic [OFF_W-1:0]   res_off;

  assign init_done_o = state_q != S_INIT;
  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign out_free    = !out_valid_q || m_axis_tready;
  assign bm_init_wa  = bm_base(ORDER_W'(MAX_ORDER));

  // Free-list update: bitmap word and summary word
  always_comb begin
    upd_pos  = upd_unit_q >> upd_k_q;
    upd_wa   = bm_base(upd_k_q) + BM_AW'(upd_pos[UNIT_W-1:6]);
    upd_word = bm_rdata_q;
    upd_word[upd_pos[5:0]] = upd_set_q;
    upd_mid  = mid_rdata_q;
    upd_mid[upd_wa[5:0]] = |upd_word;
  end

  // Search: first non-empty order, then summary bit, word and bit
  always_comb begin
    find_k  = '0;
    find_ok = 1'b0;
    for (int k = MAX_ORDER; k >= 0; k--) begin
      if ((ORDER_W'(k) >= d_q) && (cnt_q[k] != '0)) begin
        find_k  = ORDER_W'(k);
        find_ok = 1'b1;
      end
    end
    lo_f = bm_base(find_k);
    hi_f = bm_last(find_k);
    for (int m = 0; m < MID_WORDS; m++) begin
      top_mask[m] = top_q[m] && (MID_AW'(m) >= lo_f[BM_AW-1:6]) &&
                    (MID_AW'(m) <= hi_f[BM_AW-1:6]);
    end
    find_m = MID_AW'(lowest_set(64'(top_mask)));
    lo_k = bm_base(k_q);
    hi_k = bm_last(k_q);
    for (int b = 0; b < 64; b++) begin
      word_mask[b] = mid_rdata_q[b] && ({m_q, 6'(b)} >= lo_k) && ({m_q, 6'(b)} <= hi_k);
    end
    sword_wa   = {m_q, lowest_set(word_mask)};
    sbit_bit   = lowest_set(bm_rdata_q);
    sbit_unit  = UNIT_W'({UNIT_W'(9'(wa_q - lo_k)), sbit_bit} << k_q);
    split_unit = u_q + (UNIT_W'(1) << (k_q - ORDER_W'(1)));
    merge_b    = u_q ^ (UNIT_W'(1) << k_q);
  end

  assign live_ok      = tbl_rdata_q.start && !tbl_rdata_q.free;
  assign merge_ok     = tbl_rdata_q.start && tbl_rdata_q.free && (tbl_rdata_q.order == k_q);
  assign old_cap      = blk_cap(tbl_rdata_q.order, header_i);
  assign fits_inplace = cmd_q.req <= REQ_W'(old_cap);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:    if (&init_cnt_q) state_d = S_IDLE;
      S_IDLE:    if (!q_empty_i) state_d = S_DISP;
      S_DISP: begin
        case (cmd_q.action)
          ACT_STATS: state_d = S_STAT;
          ACT_FREE:  state_d = cmd_q.lk_ok ? S_LOOKCHK : S_STAT;
          ACT_RESIZE: begin
            if (cmd_q.alloc_st == ST_BAD_SIZE) state_d = S_STAT;
            else if (cmd_q.has_old) state_d = cmd_q.lk_ok ? S_LOOKCHK : S_STAT;
            else state_d = (cmd_q.alloc_st != ST_OK) ? S_STAT : S_FIND;
          end
          default:   state_d = (cmd_q.alloc_st != ST_OK) ? S_STAT : S_FIND;
        endcase
      end
      S_LOOKCHK: begin
        if (!live_ok) state_d = S_STAT;
        else if (cmd_q.action == ACT_FREE) state_d = S_FREE;
        else if (fits_inplace || (cmd_q.alloc_st != ST_OK)) state_d = S_STAT;
        else state_d = S_FIND;
      end
      S_FIND:    state_d = find_ok ? S_SWORD : S_STAT;
      S_SWORD:   state_d = S_SBIT;
      S_SBIT:    state_d = S_UPD_RD;
      S_UPD_RD:  state_d = S_UPD_WR;
      S_UPD_WR:  state_d = ret_q;
      S_SPLIT: begin
        if (k_q > d_q) state_d = S_UPD_RD;
        else state_d = free_old_q ? S_FREE : S_STAT;
      end
      S_FREE:    state_d = S_MRG_RD;
      S_MRG_RD:  state_d = (k_q < ORDER_W'(MAX_ORDER)) ? S_MRG_CHK : S_MRG_ADD;
      S_MRG_CHK: state_d = merge_ok ? S_UPD_RD : S_MRG_ADD;
      S_MRG_ADD: state_d = S_UPD_RD;
      S_STAT:    if (stat_i_q == ORDER_W'(STAT_LAST)) state_d = S_OUT;
      S_OUT:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Memory port controls
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = '0;
    tbl_wdata = '0;
    tbl_raddr = '0;
    bm_we     = 1'b0;
    bm_waddr  = '0;
    bm_wdata  = '0;
    bm_raddr  = '0;
    mid_we    = 1'b0;
    mid_waddr = '0;
    mid_wdata = '0;
    mid_raddr = '0;
    case (state_q)
      S_INIT: begin
        tbl_we    = 1'b1;
        tbl_waddr = init_cnt_q;
        if (init_cnt_q[MAX_ORDER-1:0] == '0) begin
          tbl_wdata = '{start: 1'b1, free: 1'b1, order: ORDER_W'(MAX_ORDER), size: '0};
        end
        bm_we    = 1'b1;
        bm_waddr = init_cnt_q[BM_AW-1:0];
        if (init_cnt_q[BM_AW-1:0] == bm_init_wa) begin
          bm_wdata = ~(64'hFFFF_FFFF_FFFF_FFFF << TOP_BLOCKS);
        end
        mid_we    = 1'b1;
        mid_waddr = init_cnt_q[MID_AW-1:0];
        if (init_cnt_q[MID_AW-1:0] == bm_init_wa[BM_AW-1:6]) begin
          mid_wdata[bm_init_wa[5:0]] = 1'b1;
        end
      end
      S_DISP:  tbl_raddr = cmd_q.unit;
      S_FIND:  mid_raddr = find_m;
      S_SWORD: bm_raddr  = sword_wa;
      S_UPD_RD: begin
        bm_raddr  = upd_wa;
        mid_raddr = upd_wa[BM_AW-1:6];
      end
      S_UPD_WR: begin
        bm_we     = 1'b1;
        bm_waddr  = upd_wa;
        bm_wdata  = upd_word;
        mid_we    = 1'b1;
        mid_waddr = upd_wa[BM_AW-1:6];
        mid_wdata = upd_mid;
      end
      S_SPLIT: begin
        tbl_we = 1'b1;
        if (k_q > d_q) begin
          tbl_waddr = split_unit;
          tbl_wdata = '{start: 1'b1, free: 1'b1, order: k_q - ORDER_W'(1), size: '0};
        end else begin
          tbl_waddr = u_q;
          tbl_wdata = '{start: 1'b1, free: 1'b0, order: d_q, size: cmd_q.req[SIZE_W-1:0]};
        end
      end
      S_FREE: begin
        tbl_we    = 1'b1;
        tbl_waddr = old_q;
        tbl_wdata = '{start: 1'b0, free: 1'b0, order: old_order_q, size: '0};
      end
      S_MRG_RD: tbl_raddr = merge_b;
      S_MRG_CHK: begin
        if (merge_ok) begin
          tbl_we    = 1'b1;
          tbl_waddr = b_q;
          tbl_wdata = '{start: 1'b0, free: 1'b0, order: k_q, size: '0};
        end
      end
      S_MRG_ADD: begin
        tbl_we    = 1'b1;
        tbl_waddr = u_q;
        tbl_wdata = '{start: 1'b1, free: 1'b1, order: k_q, size: '0};
      end
      default: ;
    endcase
  end

  // Memory arrays with registered reads
  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    bm_rdata_q <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mid_we) mid_mem[mid_waddr] <= mid_wdata;
    mid_rdata_q <= mid_mem[mid_raddr];
  end

  assign res_off = grant_q ? ({res_q, MIN_SHIFT'(0)} + OFF_W'(header_i)) : '0;

  // Sequencer registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      ret_q        <= S_STAT;
      init_cnt_q   <= '0;
      top_q        <= MID_WORDS'(1) << bm_init_wa[BM_AW-1:6];
      for (int k = 0; k <= MAX_ORDER; k++) begin
        cnt_q[k] <= (k == MAX_ORDER) ? CNT_W'(TOP_BLOCKS) : '0;
      end
      fbc_q        <= CNT_W'(TOP_BLOCKS);
      live_cnt_q   <= '0;
      live_bytes_q <= '0;
      stat_i_q     <= '0;
      out_valid_q  <= 1'b0;
      grant_q      <= 1'b0;
      free_old_q   <= 1'b0;
      status_q     <= ST_OK;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        S_INIT: init_cnt_q <= init_cnt_q + UNIT_W'(1);
        S_IDLE: begin
          if (!q_empty_i) begin
            cmd_q      <= q_cmd_i;
            status_q   <= ST_OK;
            grant_q    <= 1'b0;
            free_old_q <= 1'b0;
          end
        end
        S_DISP: begin
          d_q <= cmd_q.d;
          case (cmd_q.action)
            ACT_STATS: ;
            ACT_FREE:  if (!cmd_q.lk_ok) status_q <= ST_IGNORED;
            ACT_RESIZE: begin
              if (cmd_q.alloc_st == ST_BAD_SIZE) status_q <= ST_BAD_SIZE;
              else if (cmd_q.has_old) begin
                if (!cmd_q.lk_ok) status_q <= ST_IGNORED;
              end else status_q <= cmd_q.alloc_st;
            end
            default: status_q <= cmd_q.alloc_st;
          endcase
        end
        S_LOOKCHK: begin
          old_q       <= cmd_q.unit;
          old_order_q <= tbl_rdata_q.order;
          old_size_q  <= tbl_rdata_q.size;
          if (!live_ok) status_q <= ST_IGNORED;
          else if (cmd_q.action == ACT_RESIZE) begin
            if (fits_inplace) begin
              grant_q <= 1'b1;
              res_q   <= cmd_q.unit;
            end else if (cmd_q.alloc_st != ST_OK) begin
              status_q <= cmd_q.alloc_st;
            end else begin
              free_old_q <= 1'b1;
            end
          end
        end
        S_FIND: begin
          if (!find_ok) status_q <= ST_NO_MEM;
          k_q <= find_k;
          m_q <= find_m;
        end
        S_SWORD: wa_q <= sword_wa;
        S_SBIT: begin
          u_q        <= sbit_unit;
          upd_unit_q <= sbit_unit;
          upd_k_q    <= k_q;
          upd_set_q  <= 1'b0;
          ret_q      <= S_SPLIT;
        end
        S_UPD_WR: begin
          top_q[upd_wa[BM_AW-1:6]] <= |upd_mid;
          if (upd_set_q) begin
            cnt_q[upd_k_q] <= cnt_q[upd_k_q] + CNT_W'(1);
            fbc_q          <= fbc_q + CNT_W'(1);
          end else begin
            cnt_q[upd_k_q] <= cnt_q[upd_k_q] - CNT_W'(1);
            fbc_q          <= fbc_q - CNT_W'(1);
          end
        end
        S_SPLIT: begin
          if (k_q > d_q) begin
            // Put the upper half on the next order down
            upd_unit_q <= split_unit;
            upd_k_q    <= k_q - ORDER_W'(1);
            upd_set_q  <= 1'b1;
            ret_q      <= S_SPLIT;
            k_q        <= k_q - ORDER_W'(1);
          end else begin
            live_cnt_q   <= live_cnt_q + CNT_W'(1);
            live_bytes_q <= live_bytes_q + BYTES_W'(cmd_q.req[SIZE_W-1:0]);
            grant_q      <= 1'b1;
            res_q        <= u_q;
          end
        end
        S_FREE: begin
          k_q          <= old_order_q;
          u_q          <= old_q;
          live_cnt_q   <= live_cnt_q - CNT_W'(1);
          live_bytes_q <= live_bytes_q - BYTES_W'(old_size_q);
        end
        S_MRG_RD: b_q <= merge_b;
        S_MRG_CHK: begin
          if (merge_ok) begin
            // Drop the buddy from its list and keep the lower address
            upd_unit_q <= b_q;
            upd_k_q    <= k_q;
            upd_set_q  <= 1'b0;
            ret_q      <= S_MRG_RD;
            u_q        <= (b_q < u_q) ? b_q : u_q;
            k_q        <= k_q + ORDER_W'(1);
          end
        end
        S_MRG_ADD: begin
          upd_unit_q <= u_q;
          upd_k_q    <= k_q;
          upd_set_q  <= 1'b1;
          ret_q      <= S_STAT;
        end
        S_STAT: begin
          // One product per order, accumulated in the next cycle
          if (stat_i_q <= ORDER_W'(MAX_ORDER)) begin
            prod_q <= TBYTES_W'(cnt_q[stat_i_q]) * TBYTES_W'(blk_cap(stat_i_q, header_i));
          end
          if (stat_i_q == '0) acc_q <= '0;
          else acc_q <= acc_q + prod_q;
          if (stat_i_q != ORDER_W'(STAT_LAST)) stat_i_q <= stat_i_q + ORDER_W'(1);
        end
        S_OUT: begin
          if (out_free) begin
            stat_i_q   <= '0;
            out_data_q <= {acc_q + TBYTES_W'(live_bytes_q),
                           live_cnt_q + fbc_q,
                           acc_q[BYTES_W-1:0],
                           fbc_q,
                           res_off,
                           status_q};
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/buddy_block_allocator_unit.sv
// Top level of the buddy block allocator: header register, front end,
// request queue and back end. Depends on bba_pkg, bba_front, bba_queue, bba_back.
//
// Buddy allocator over a 4 MiB region of 32 top-order blocks of 128 KiB, one
// result per request. After reset a clearing pass fills the 32768-entry
// block table, one entry a cycle, and no request is taken until it ends;
// header writes are taken throughout. The shortest requests are an ignored
// free and a statistics request; the longest pass through dispatch, a table
// lookup, a free-list search, a read and a write per free-list update on the
// bitmap and summary memory ports, one table access per split or merge step
// (up to ten each), and statistics summed order by order through a single
// multiplier. The queue and the output register let a new request enter
// while a result waits to be taken.
module buddy_block_allocator_unit import bba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [HDR_W-1:0] cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // action[1:0], request_bytes[28:2], payload_offset[50:29], has_old[51], zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status[2:0], result_offset[24:3], free_blocks[40:25],
  // free_payload_bytes[63:41], total_blocks[79:64], total_bytes[103:80]
  output logic [OUT_W-1:0] m_axis_tdata
);

  logic [HDR_W-1:0] header_q;
  logic             push, pop, q_full, q_empty, init_done;
  cmd_t             f_cmd, q_cmd;

  assign cfg_ready_o = 1'b1;

  // Hold the header size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HDR_W'(HDR_RESET);
    end else if (cfg_valid_i) begin
      header_q <= cfg_data_i;
    end
  end

  bba_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .header_i      (header_q),
    .q_full_i      (q_full),
    .init_done_i   (init_done),
    .push_o        (push),
    .cmd_o         (f_cmd)
  );

  bba_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (f_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .cmd_o   (q_cmd)
  );

  bba_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .header_i      (header_q),
    .q_empty_i     (q_empty),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (pop),
    .init_done_o   (init_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: rtl/bba_checker.sv
// Port-level checks on the allocator's result stream, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator_unit.
module bba_port_checks import bba_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Status codes stay in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_IGNORED)
    else $error("status out of range");

  // No offset without a grant
  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] != ST_OK) |-> m_axis_tdata[24:3] == '0)
    else $error("offset given on a failed request");

  // Free blocks never exceed all blocks
  a_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[40:25] <= m_axis_tdata[79:64])
    else $error("free blocks exceed total blocks");

  // Free payload never exceeds total bytes
  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 24'(m_axis_tdata[63:41]) <= m_axis_tdata[103:80])
    else $error("free payload exceeds total bytes");

endmodule

bind buddy_block_allocator_unit bba_port_checks u_bba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
